FILE: sv/poly_voice_allocator_arpeggiator_top_assert.svh
// Assertion macros for the voice allocator top level.
`ifndef POLY_VOICE_ALLOCATOR_ARPEGGIATOR_TOP_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ARPEGGIATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PVA_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PVA_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pva_pkg.sv
// Shared types and constants of the voice allocator.
`default_nettype none
package pva_pkg;

    localparam int VOICES  = 8;
    localparam int NOTES   = 128;
    localparam int NOTE_AW = (NOTES > 1) ? $clog2(NOTES) : 1;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_START  = 3'd1;
    localparam logic [2:0] EV_STOP   = 3'd2;
    localparam logic [2:0] EV_RETUNE = 3'd3;
    localparam logic [2:0] EV_NOFREE = 3'd4;

    localparam logic [3:0] STEP_ROOT  = 4'd1;
    localparam logic [3:0] STEP_FIFTH = 4'd5;
    localparam logic [3:0] STEP_SIXTH = 4'd8;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] note;
    } t_in_word;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] voice;
        logic [7:0] pitch;
    } t_out_word;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage
`default_nettype wire

FILE: sv/pva_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: sv/pva_ctrl.sv
// Controller: load cycle reads the map, exec cycle applies the word.
`default_nettype none
module pva_ctrl (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    output pva_pkg::t_ctrl o_cmd
);

    pva_pkg::t_state r_state;
    pva_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pva_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        busy       = 1'b0;
        unique case (r_state)
            pva_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = pva_pkg::ST_EXEC;
                end
            end
            pva_pkg::ST_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
                n_state    = pva_pkg::ST_IDLE;
            end
            default: begin
                n_state = pva_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/pva_dp.sv
// Datapath: note map, voice busy bits, arpeggio state and result register.
`default_nettype none
module pva_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pva_pkg::t_ctrl    i_cmd,
    input  wire pva_pkg::t_in_word i_in,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    output logic                   o_res_strobe,
    output pva_pkg::t_out_word     o_res
);

    localparam int AW = pva_pkg::NOTE_AW;

    logic [1:0]                 r_op;
    logic [6:0]                 r_note;
    logic [pva_pkg::NOTES-1:0]  r_valid;
    logic [pva_pkg::NOTES-1:0]  n_valid;
    logic [pva_pkg::VOICES-1:0] r_busy;
    logic [pva_pkg::VOICES-1:0] n_busy;
    logic [6:0]                 r_root;
    logic [6:0]                 n_root;
    logic [3:0]                 r_step;
    logic [3:0]                 n_step;
    logic                       r_arp_en;
    pva_pkg::t_out_word         n_res;

    logic [2:0] map_rdata;
    logic       map_we;
    logic [2:0] map_wdata;
    logic       in_range;
    logic       hit;
    logic       free_found;
    logic [2:0] free_idx;

    // voice index per note; valid bits live in r_valid
    pva_ram #(
        .WIDTH (3),
        .DEPTH (pva_pkg::NOTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_note[AW-1:0]),
        .i_wdata (map_wdata),
        .i_raddr (i_in.note[AW-1:0]),
        .o_rdata (map_rdata)
    );

    // lowest free voice
    always_comb begin
        free_found = 1'b0;
        free_idx   = 3'd0;
        for (int i = pva_pkg::VOICES - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = 3'(i);
            end
        end
    end

    assign in_range = ({1'b0, r_note} < 8'(pva_pkg::NOTES));
    assign hit      = in_range && r_valid[r_note[AW-1:0]];

    always_comb begin
        n_valid   = r_valid;
        n_busy    = r_busy;
        n_root    = r_root;
        n_step    = r_step;
        map_we    = 1'b0;
        map_wdata = free_idx;
        n_res     = '0;
        unique case (r_op)
            pva_pkg::OP_NOTE_ON: begin
                if (in_range && !hit) begin
                    n_root = r_note;
                    if (free_found) begin
                        n_busy[free_idx]          = 1'b1;
                        n_valid[r_note[AW-1:0]]   = 1'b1;
                        map_we                    = i_cmd.exec;
                        n_res.event_res           = pva_pkg::EV_START;
                        n_res.voice               = free_idx;
                    end else begin
                        n_res.event_res = pva_pkg::EV_NOFREE;
                    end
                    n_res.pitch = {1'b0, r_note};
                end
            end
            pva_pkg::OP_NOTE_OFF: begin
                if (hit) begin
                    n_busy[map_rdata]       = 1'b0;
                    n_valid[r_note[AW-1:0]] = 1'b0;
                    n_res.event_res         = pva_pkg::EV_STOP;
                    n_res.voice             = map_rdata;
                    n_res.pitch             = {1'b0, r_note};
                end
            end
            pva_pkg::OP_TICK: begin
                if (r_arp_en && r_busy[0]) begin
                    unique case (r_step)
                        pva_pkg::STEP_ROOT:  n_step = pva_pkg::STEP_FIFTH;
                        pva_pkg::STEP_FIFTH: n_step = pva_pkg::STEP_SIXTH;
                        default:             n_step = pva_pkg::STEP_ROOT;
                    endcase
                    n_res.event_res = pva_pkg::EV_RETUNE;
                    n_res.pitch     = {1'b0, r_root} + {4'b0, n_step};
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_busy       <= '0;
            r_step       <= pva_pkg::STEP_ROOT;
            r_arp_en     <= 1'b0;
            o_res_strobe <= 1'b0;
        end else begin
            o_res_strobe <= i_cmd.exec;
            if (i_cfg_we) begin
                r_arp_en <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_valid <= n_valid;
                r_busy  <= n_busy;
                r_step  <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in.opcode;
            r_note <= i_in.note;
        end
        if (i_cmd.exec) begin
            r_root <= n_root;
            o_res  <= n_res;
        end
    end

endmodule
`default_nettype wire

FILE: sv/poly_voice_allocator_arpeggiator_top.sv
// A word and its map RAM read are registered in the load cycle; its result and strobe
// are registered, with write-back, in the execute cycle; no word is taken while busy.
// busy is high during the execute cycle; results cannot be stalled.
// Reset (synchronous, active low) clears all note mappings, voice busy bits,
// arp_enable, and sets the arpeggio step to 1; no clearing pass is needed.
`default_nettype none
`include "poly_voice_allocator_arpeggiator_top_assert.svh"
module poly_voice_allocator_arpeggiator_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pva_pkg::t_in_word i_in,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    output logic                   o_res_strobe,
    output pva_pkg::t_out_word     o_res
);

    pva_pkg::t_ctrl cmd;

    pva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    pva_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    `PVA_CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `PVA_CHK_NOW(a_strobe_src, o_res_strobe, $past(start && !busy, 2), "result without word")
    `PVA_CHK_NOW(a_strobe_idle, o_res_strobe, !busy, "result strobe while busy")
    `PVA_CHK_NOW(a_voice_zero,
        o_res_strobe && (o_res.event_res == pva_pkg::EV_NONE ||
                         o_res.event_res == pva_pkg::EV_NOFREE),
        o_res.voice == 3'd0, "nonzero voice on no-action result")

endmodule
`default_nettype wire
